// ----- rtl/core/tso_pkg.sv -----
// Shared types, codes and helpers of the timestamp oracle.
package tso_pkg;

	localparam int PHYS_W     = 48;
	localparam int LOG_W      = 30;
	localparam int CNT_W      = 30;
	localparam int CMD_W      = 3;
	localparam int STAT_W     = 3;
	localparam int LIM_W      = 31;
	localparam int GUARD_W    = 16;
	localparam int SAVE_INT_W = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	localparam logic [PHYS_W-1:0] PHYS_MAX = {PHYS_W{1'b1}};
	localparam logic [LIM_W-1:0]  LOG_SPAN = LIM_W'(64'd1 << LOG_W);

	localparam logic [CMD_W-1:0] CMD_GEN        = 3'd0;
	localparam logic [CMD_W-1:0] CMD_TICK       = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RESET      = 3'd2;
	localparam logic [CMD_W-1:0] CMD_UPDATE     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;
	localparam logic [CMD_W-1:0] CMD_LEAD_START = 3'd5;
	localparam logic [CMD_W-1:0] CMD_LEAD_STOP  = 3'd6;

	localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
	localparam logic [STAT_W-1:0] ST_BAD_COUNT  = 3'd1;
	localparam logic [STAT_W-1:0] ST_UNHEALTHY  = 3'd2;
	localparam logic [STAT_W-1:0] ST_EXHAUSTED  = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOT_LEADER = 3'd4;
	localparam logic [STAT_W-1:0] ST_FALLBACK   = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_LOGICAL_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GUARD         = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAVE_INT      = 2'd2;

	localparam logic [LIM_W-1:0]      RST_LOGICAL_LIMIT = 31'd262144;
	localparam logic [GUARD_W-1:0]    RST_GUARD         = 16'd3;
	localparam logic [SAVE_INT_W-1:0] RST_SAVE_INT      = 24'd3000;

	typedef enum logic [2:0] {
		OP_GEN,
		OP_TICK,
		OP_RESET,
		OP_UPDATE,
		OP_QUERY,
		OP_LEAD_START,
		OP_LEAD_STOP
	} op_t;

	typedef struct packed {
		logic [LIM_W-1:0]      logical_limit;
		logic [GUARD_W-1:0]    guard_ms;
		logic [SAVE_INT_W-1:0] bound_lead_ms;
	} tso_cfg_t;

	typedef struct packed {
		op_t               op;
		logic [CNT_W-1:0]  count;
		logic [PHYS_W-1:0] now_ms;
		logic [PHYS_W:0]   now_g;
		logic [PHYS_W-1:0] now_save;
		logic [PHYS_W-1:0] req_physical;
		logic [LOG_W-1:0]  req_logical;
		logic [PHYS_W-1:0] req_save;
		logic              force_req;
	} tso_entry_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} tso_qstat_t;

	function automatic logic [PHYS_W-1:0] sat_phys(input logic [PHYS_W+1:0] s);
		return (s > {2'b00, PHYS_MAX}) ? PHYS_MAX : s[PHYS_W-1:0];
	endfunction

endpackage

// ----- rtl/core/tso_req_if.sv -----
// Request channel of the timestamp oracle.
interface tso_req_if;
	import tso_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [CNT_W-1:0]  count;
	logic [PHYS_W-1:0] now_ms;
	logic [PHYS_W-1:0] req_physical;
	logic [LOG_W-1:0]  req_logical;
	logic [PHYS_W-1:0] req_save;
	logic              force_req;

	modport source(output valid, cmd, count, now_ms, req_physical, req_logical, req_save,
		force_req, input ready);
	modport sink(input valid, cmd, count, now_ms, req_physical, req_logical, req_save,
		force_req, output ready);
endinterface

// ----- rtl/core/tso_rsp_if.sv -----
// Response channel of the timestamp oracle.
interface tso_rsp_if;
	import tso_pkg::*;

	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [PHYS_W-1:0] ts_physical;
	logic [LOG_W-1:0]  ts_logical;
	logic [PHYS_W-1:0] save_bound;
	logic [CNT_W-1:0]  granted;
	logic              leader_flag;

	modport source(output valid, status, ts_physical, ts_logical, save_bound, granted,
		leader_flag, input ready);
	modport sink(input valid, status, ts_physical, ts_logical, save_bound, granted,
		leader_flag, output ready);
endinterface

// ----- rtl/core/tso_cfg_if.sv -----
// Configuration write channel of the timestamp oracle.
interface tso_cfg_if;
	import tso_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/core/tso_cfg_regs.sv -----
// Configuration registers of the timestamp oracle.
module tso_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	tso_cfg_if.sink           cfg,
	output tso_pkg::tso_cfg_t regs
);
	import tso_pkg::*;

	tso_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.logical_limit <= RST_LOGICAL_LIMIT;
			regs_q.guard_ms      <= RST_GUARD;
			regs_q.bound_lead_ms <= RST_SAVE_INT;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_LOGICAL_LIMIT: begin
					regs_q.logical_limit <= cfg.data[LIM_W-1:0];
				end
				REG_GUARD: begin
					regs_q.guard_ms <= cfg.data[GUARD_W-1:0];
				end
				REG_SAVE_INT: begin
					regs_q.bound_lead_ms <= cfg.data[SAVE_INT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end
endmodule

// ----- rtl/core/tso_front.sv -----
// Front end: accept requests, decode the command, precompute wall-clock sums.
module tso_front (
	tso_req_if.sink              req,
	input  tso_pkg::tso_cfg_t    cfg,
	input  tso_pkg::tso_qstat_t  qstat,
	output logic                 push,
	output tso_pkg::tso_entry_t  entry
);
	import tso_pkg::*;

	op_t op;

	assign req.ready = !qstat.full;
	assign push      = req.valid && !qstat.full;

	always_comb begin
		unique case (req.cmd)
			CMD_GEN:        op = OP_GEN;
			CMD_TICK:       op = OP_TICK;
			CMD_RESET:      op = OP_RESET;
			CMD_UPDATE:     op = OP_UPDATE;
			CMD_LEAD_START: op = OP_LEAD_START;
			CMD_LEAD_STOP:  op = OP_LEAD_STOP;
			default:        op = OP_QUERY;
		endcase
	end

	always_comb begin
		entry.op           = op;
		entry.count        = req.count;
		entry.now_ms       = req.now_ms;
		entry.now_g        = (PHYS_W+1)'(req.now_ms) + (PHYS_W+1)'(cfg.guard_ms);
		entry.now_save     = sat_phys((PHYS_W+2)'(req.now_ms)
			+ (PHYS_W+2)'(cfg.bound_lead_ms));
		entry.req_physical = req.req_physical;
		entry.req_logical  = req.req_logical;
		entry.req_save     = req.req_save;
		entry.force_req    = req.force_req;
	end
endmodule

// ----- rtl/core/tso_queue.sv -----
// Two-entry queue between the front end and the execution unit.
module tso_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  tso_pkg::tso_entry_t  wr_entry,
	input  logic                 pop,
	output tso_pkg::tso_entry_t  rd_entry,
	output tso_pkg::tso_qstat_t  qstat
);
	import tso_pkg::*;

	tso_entry_t        mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign qstat.full      = (cnt_q == QCNT_W'(QDEPTH));
	assign qstat.not_empty = (cnt_q != '0);
	assign rd_entry        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end
endmodule

// ----- rtl/core/tso_back.sv -----
// Execution unit: oracle state, command execution and the response register.
module tso_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tso_pkg::tso_cfg_t    cfg,
	input  tso_pkg::tso_entry_t  entry,
	input  tso_pkg::tso_qstat_t  qstat,
	output logic                 pop,
	tso_rsp_if.source            rsp
);
	import tso_pkg::*;

	logic [PHYS_W-1:0] phys_q;
	logic [LOG_W-1:0]  logical_q;
	logic [PHYS_W-1:0] save_q;
	logic              healthy_q;
	logic              leader_q;

	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [PHYS_W-1:0] ts_phys_q;
	logic [LOG_W-1:0]  ts_log_q;
	logic [PHYS_W-1:0] save_bound_q;
	logic [CNT_W-1:0]  granted_q;
	logic              leader_flag_q;

	logic [PHYS_W-1:0] n_phys;
	logic [LOG_W-1:0]  n_log;
	logic [PHYS_W-1:0] n_save;
	logic              n_healthy;
	logic              n_leader;
	logic [STAT_W-1:0] n_status;
	logic [CNT_W-1:0]  n_granted;
	logic              gen_ok;

	logic [LIM_W-1:0]  lim;
	logic [LIM_W-1:0]  nl;
	logic [LOG_W-1:0]  half;
	logic [PHYS_W:0]   phys_g;
	logic [PHYS_W-1:0] ps;
	logic [PHYS_W:0]   ps_g;
	logic [PHYS_W-1:0] ps_save;
	logic [PHYS_W:0]   save_g;
	logic [PHYS_W-1:0] floor_t;
	logic [PHYS_W-1:0] floor_save;
	logic              ls_low;
	logic [PHYS_W-1:0] ls_p;
	logic [PHYS_W-1:0] ls_s;
	logic              ls_fall;
	logic              tk_now;
	logic              tk_guard;
	logic [PHYS_W-1:0] tk_next;
	logic [PHYS_W:0]   tk_next_g;
	logic [PHYS_W-1:0] tk_cand;
	logic [PHYS_W-1:0] tk_save;
	logic              tk_fall;
	logic              rq_fall;

	assign pop = qstat.not_empty && (!out_valid_q || rsp.ready);

	always_comb begin
		lim      = (cfg.logical_limit < LOG_SPAN) ? cfg.logical_limit : LOG_SPAN;
		nl       = LIM_W'(logical_q) + LIM_W'(entry.count);
		half     = cfg.logical_limit[LIM_W-1:1];

		phys_g   = (PHYS_W+1)'(phys_q) + (PHYS_W+1)'(cfg.guard_ms);
		ps       = sat_phys((PHYS_W+2)'(phys_g));
		ps_g     = (PHYS_W+1)'(ps) + (PHYS_W+1)'(cfg.guard_ms);
		ps_save  = sat_phys((PHYS_W+2)'(phys_q) + (PHYS_W+2)'(cfg.guard_ms)
			+ (PHYS_W+2)'(cfg.bound_lead_ms));

		save_g     = (PHYS_W+1)'(save_q) + (PHYS_W+1)'(cfg.guard_ms);
		floor_t    = sat_phys((PHYS_W+2)'(save_g));
		floor_save = sat_phys((PHYS_W+2)'(save_q) + (PHYS_W+2)'(cfg.guard_ms)
			+ (PHYS_W+2)'(cfg.bound_lead_ms));
		ls_low     = ((PHYS_W+1)'(entry.now_ms) < save_g);
		ls_p       = ls_low ? floor_t : entry.now_ms;
		ls_s       = ls_low ? floor_save : entry.now_save;
		ls_fall    = (ls_s < save_q) || (ls_p < phys_q);

		tk_now    = ((PHYS_W+1)'(entry.now_ms) > phys_g);
		tk_guard  = (logical_q > half);
		tk_next   = tk_now ? entry.now_ms : ps;
		tk_next_g = tk_now ? entry.now_g : ps_g;
		tk_cand   = tk_now ? entry.now_save : ps_save;
		tk_save   = ((PHYS_W+1)'(save_q) <= tk_next_g) ? tk_cand : save_q;
		tk_fall   = (tk_save < save_q) || (tk_next < phys_q);

		rq_fall = (entry.req_save < save_q) || (entry.req_physical < phys_q);
	end

	always_comb begin
		n_phys    = phys_q;
		n_log     = logical_q;
		n_save    = save_q;
		n_healthy = healthy_q;
		n_leader  = leader_q;
		n_status  = ST_OK;
		n_granted = '0;
		gen_ok    = 1'b0;
		unique case (entry.op)
			OP_GEN: begin
				priority if (!leader_q) begin
					n_status = ST_NOT_LEADER;
				end else if (entry.count == '0) begin
					n_status = ST_BAD_COUNT;
				end else if (!healthy_q) begin
					n_status = ST_UNHEALTHY;
				end else if ((phys_q == '0) || (nl >= lim)) begin
					n_status = ST_EXHAUSTED;
				end else begin
					n_log     = nl[LOG_W-1:0];
					n_granted = entry.count;
					gen_ok    = 1'b1;
				end
			end
			OP_TICK: begin
				priority if (!leader_q) begin
					n_status = ST_NOT_LEADER;
				end else if (tk_now || tk_guard) begin
					if (tk_fall) begin
						n_status = ST_FALLBACK;
					end else begin
						n_phys = tk_next;
						n_log  = '0;
						n_save = tk_save;
					end
				end else begin
				end
			end
			OP_RESET: begin
				priority if (!leader_q) begin
					n_status = ST_NOT_LEADER;
				end else if (rq_fall && !entry.force_req) begin
					n_status = ST_FALLBACK;
				end else begin
					n_healthy = 1'b1;
					n_phys    = entry.req_physical;
					n_log     = entry.req_logical;
					n_save    = entry.req_save;
				end
			end
			OP_UPDATE: begin
				priority if (!leader_q) begin
					n_status = ST_NOT_LEADER;
				end else if (rq_fall) begin
					n_status = ST_FALLBACK;
				end else begin
					n_phys = entry.req_physical;
					n_log  = entry.req_logical;
					n_save = entry.req_save;
				end
			end
			OP_LEAD_START: begin
				if (ls_fall) begin
					n_healthy = 1'b0;
					n_status  = ST_FALLBACK;
				end else begin
					n_phys = ls_p;
					n_log  = '0;
					n_save = ls_s;
				end
				n_leader = 1'b1;
			end
			OP_LEAD_STOP: begin
				n_leader = 1'b0;
			end
			OP_QUERY: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phys_q      <= '0;
			logical_q   <= '0;
			save_q      <= '0;
			healthy_q   <= 1'b1;
			leader_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phys_q      <= n_phys;
				logical_q   <= n_log;
				save_q      <= n_save;
				healthy_q   <= n_healthy;
				leader_q    <= n_leader;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q      <= n_status;
			ts_phys_q     <= n_phys;
			ts_log_q      <= gen_ok ? logical_q : n_log;
			save_bound_q  <= n_save;
			granted_q     <= n_granted;
			leader_flag_q <= n_leader;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.ts_physical = ts_phys_q;
	assign rsp.ts_logical  = ts_log_q;
	assign rsp.save_bound  = save_bound_q;
	assign rsp.granted     = granted_q;
	assign rsp.leader_flag = leader_flag_q;
endmodule

// ----- rtl/core/timestamp_oracle.sv -----
// Top level of the timestamp oracle.
//
//   channel  direction  handshake     payload
//   cfg      in         valid/ready   index, data (register write)
//   req      in         valid/ready   cmd, count, now_ms, req_*, force_req
//   rsp      out        valid/ready   status, ts_*, save_bound, granted, leader_flag
//
// One request per cycle sustained while rsp.ready stays high; an accepted request is written
// into the two-entry queue and executed from there into the response register.
// The execution unit updates the oracle state and loads the response register in one step.
// arst_n clears the queue, the state (healthy set) and loads the register defaults.
// A stalled rsp holds its register; the queue fills and then drops req.ready.
module timestamp_oracle (
	input  logic      clk,
	input  logic      arst_n,
	tso_cfg_if.sink   cfg,
	tso_req_if.sink   req,
	tso_rsp_if.source rsp
);
	import tso_pkg::*;

	tso_cfg_t   regs;
	tso_qstat_t qstat;
	tso_entry_t wr_entry;
	tso_entry_t rd_entry;
	logic       push;
	logic       pop;

	tso_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	tso_front u_front (
		.req   (req),
		.cfg   (regs),
		.qstat (qstat),
		.push  (push),
		.entry (wr_entry)
	);

	tso_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.qstat    (qstat)
	);

	tso_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (regs),
		.entry  (rd_entry),
		.qstat  (qstat),
		.pop    (pop),
		.rsp    (rsp)
	);
endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench of the timestamp oracle: directed script, then random traffic.
`timescale 1ns / 1ps

module testbench;
	import tso_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;
	localparam logic [LOG_W-1:0] LOG_TOP = '1;
	localparam logic [CNT_W-1:0] CNT_TOP = '1;
	localparam int ITEMS_PER_PHASE = 175;
	localparam int PHASES = 6;
	localparam int QUIET_LIMIT = 4000;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [CNT_W-1:0]  count;
		logic [PHYS_W-1:0] now_ms;
		logic [PHYS_W-1:0] req_physical;
		logic [LOG_W-1:0]  req_logical;
		logic [PHYS_W-1:0] req_save;
		logic              force_req;
	} stamp_req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [PHYS_W-1:0] ts_physical;
		logic [LOG_W-1:0]  ts_logical;
		logic [PHYS_W-1:0] save_bound;
		logic [CNT_W-1:0]  granted;
		logic              leader_flag;
	} stamp_rsp_t;

	typedef struct packed {
		stamp_req_t q;
		logic       fixed;
		stamp_rsp_t answer;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tso_cfg_if cfg_bus();
	tso_req_if req_bus();
	tso_rsp_if rsp_bus();

	timestamp_oracle dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.req(req_bus),
		.rsp(rsp_bus)
	);

	always #2 clk = ~clk;

	logic [LIM_W-1:0]      lim_reg = RST_LOGICAL_LIMIT;
	logic [GUARD_W-1:0]    guard_reg = RST_GUARD;
	logic [SAVE_INT_W-1:0] sint_reg = RST_SAVE_INT;

	logic [PHYS_W-1:0] ts_phys = '0;
	logic [LOG_W-1:0]  ts_log = '0;
	logic [PHYS_W-1:0] bound = '0;
	logic              is_healthy = 1'b1;
	logic              is_leader = 1'b0;

	stamp_rsp_t owed_stamps[$];
	int stamps_in_flight = 0;
	int sent = 0;
	int taken = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int send_gap_pct = 12;
	int take_stall_pct = 57;
	logic use_fixed = 1'b0;
	stamp_rsp_t fixed_answer = '0;

	function automatic logic [PHYS_W-1:0] clamp_phys(input logic [PHYS_W+1:0] s);
		return (s > {2'b00, PHYS_MAX}) ? PHYS_MAX : s[PHYS_W-1:0];
	endfunction

	function automatic logic [PHYS_W-1:0] phys_plus(input logic [PHYS_W-1:0] a,
		input int unsigned d);
		return clamp_phys({2'b00, a} + (PHYS_W+2)'(d));
	endfunction

	function automatic logic [PHYS_W-1:0] any_phys();
		return PHYS_W'({$urandom, $urandom});
	endfunction

	function automatic logic [LIM_W-1:0] logical_span();
		return (lim_reg < LOG_SPAN) ? lim_reg : LOG_SPAN;
	endfunction

	function automatic logic load_if_forward(input logic [PHYS_W-1:0] phys,
		input logic [LOG_W-1:0] logv, input logic [PHYS_W-1:0] save);
		if (save < bound || phys < ts_phys)
			return 1'b0;
		ts_phys = phys;
		ts_log = logv;
		bound = save;
		return 1'b1;
	endfunction

	function automatic stamp_rsp_t oracle_answer(input stamp_req_t q);
		stamp_rsp_t r;
		logic [LOG_W:0] next_log;
		logic [PHYS_W-1:0] nxt;
		logic [PHYS_W-1:0] new_save;
		logic [PHYS_W-1:0] floor_t;
		logic [PHYS_W-1:0] p;
		logic advance;
		logic granted_ok;
		r = '0;
		r.status = ST_OK;
		granted_ok = 1'b0;
		advance = 1'b0;
		nxt = '0;
		if (q.cmd <= CMD_UPDATE && !is_leader) begin
			r.status = ST_NOT_LEADER;
		end else begin
			case (q.cmd)
				CMD_GEN: begin
					next_log = {1'b0, ts_log} + {1'b0, q.count};
					if (q.count == '0) begin
						r.status = ST_BAD_COUNT;
					end else if (!is_healthy) begin
						r.status = ST_UNHEALTHY;
					end else if (ts_phys == '0 || next_log >= logical_span()) begin
						r.status = ST_EXHAUSTED;
					end else begin
						r.ts_physical = ts_phys;
						r.ts_logical = ts_log;
						r.granted = q.count;
						ts_log = next_log[LOG_W-1:0];
						granted_ok = 1'b1;
					end
				end
				CMD_TICK: begin
					if ({2'b00, q.now_ms} > {2'b00, ts_phys} + (PHYS_W+2)'(guard_reg)) begin
						nxt = q.now_ms;
						advance = 1'b1;
					end else if ({1'b0, ts_log} > (lim_reg >> 1)) begin
						nxt = clamp_phys({2'b00, ts_phys} + (PHYS_W+2)'(guard_reg));
						advance = 1'b1;
					end
					if (advance) begin
						new_save = bound;
						if ({2'b00, bound} <= {2'b00, nxt} + (PHYS_W+2)'(guard_reg))
							new_save = clamp_phys({2'b00, nxt} + (PHYS_W+2)'(sint_reg));
						if (!load_if_forward(nxt, '0, new_save))
							r.status = ST_FALLBACK;
					end
				end
				CMD_RESET: begin
					if ((q.req_save < bound || q.req_physical < ts_phys) && !q.force_req) begin
						r.status = ST_FALLBACK;
					end else begin
						is_healthy = 1'b1;
						ts_phys = q.req_physical;
						ts_log = q.req_logical;
						bound = q.req_save;
					end
				end
				CMD_UPDATE: begin
					if (!load_if_forward(q.req_physical, q.req_logical, q.req_save))
						r.status = ST_FALLBACK;
				end
				CMD_LEAD_START: begin
					floor_t = clamp_phys({2'b00, bound} + (PHYS_W+2)'(guard_reg));
					p = (q.now_ms < floor_t) ? floor_t : q.now_ms;
					if (!load_if_forward(p, '0,
						clamp_phys({2'b00, p} + (PHYS_W+2)'(sint_reg)))) begin
						is_healthy = 1'b0;
						r.status = ST_FALLBACK;
					end
					is_leader = 1'b1;
				end
				CMD_LEAD_STOP: begin
					is_leader = 1'b0;
				end
				default: begin
				end
			endcase
		end
		if (!granted_ok) begin
			r.ts_physical = ts_phys;
			r.ts_logical = ts_log;
		end
		r.save_bound = bound;
		r.leader_flag = is_leader;
		return r;
	endfunction

	function automatic stamp_req_t req_of(input logic [CMD_W-1:0] cmd,
		input logic [CNT_W-1:0] count, input logic [PHYS_W-1:0] now_ms,
		input logic [PHYS_W-1:0] rphys, input logic [LOG_W-1:0] rlog,
		input logic [PHYS_W-1:0] rsave, input logic frc);
		stamp_req_t q;
		q.cmd = cmd;
		q.count = count;
		q.now_ms = now_ms;
		q.req_physical = rphys;
		q.req_logical = rlog;
		q.req_save = rsave;
		q.force_req = frc;
		return q;
	endfunction

	function automatic stamp_rsp_t rsp_of(input logic [STAT_W-1:0] status,
		input logic [PHYS_W-1:0] phys, input logic [LOG_W-1:0] logv,
		input logic [PHYS_W-1:0] save, input logic [CNT_W-1:0] granted, input logic lead);
		stamp_rsp_t r;
		r.status = status;
		r.ts_physical = phys;
		r.ts_logical = logv;
		r.save_bound = save;
		r.granted = granted;
		r.leader_flag = lead;
		return r;
	endfunction

	function automatic stamp_req_t next_request();
		stamp_req_t q;
		int unsigned pick;
		logic [LIM_W-1:0] span;
		logic [LIM_W-1:0] room;
		span = logical_span();
		room = (span > {1'b0, ts_log}) ? span - {1'b0, ts_log} : '0;
		q.count = CNT_W'($urandom);
		q.now_ms = any_phys();
		q.req_physical = any_phys();
		q.req_logical = LOG_W'($urandom);
		q.req_save = any_phys();
		q.force_req = 1'($urandom_range(1));
		pick = $urandom_range(99);
		if (!is_leader && pick < 60)
			q.cmd = CMD_LEAD_START;
		else if (pick < 40)
			q.cmd = CMD_GEN;
		else if (pick < 56)
			q.cmd = CMD_TICK;
		else if (pick < 65)
			q.cmd = CMD_RESET;
		else if (pick < 74)
			q.cmd = CMD_UPDATE;
		else if (pick < 80)
			q.cmd = CMD_QUERY;
		else if (pick < 88)
			q.cmd = CMD_LEAD_START;
		else if (pick < 95)
			q.cmd = CMD_LEAD_STOP;
		else
			q.cmd = CMD_SPARE;
		case ($urandom_range(9))
			0: q.count = '0;
			1: ;
			2: q.count = (room > 1) ? CNT_W'(room - LIM_W'($urandom_range(1))) : CNT_W'(1);
			default: q.count = CNT_W'($urandom_range(1, (span > 64) ? span >> 4 : 4));
		endcase
		pick = $urandom_range(19);
		if (pick < 17)
			q.now_ms = phys_plus(ts_phys, $urandom_range(0, 2 * guard_reg + 40));
		else if (pick == 17)
			q.now_ms = PHYS_MAX;
		else if (pick == 18)
			q.now_ms = PHYS_W'($urandom_range(0, 5000));
		pick = $urandom_range(9);
		if (pick < 5) begin
			q.req_physical = phys_plus(ts_phys, $urandom_range(0, 3000));
			q.req_save = phys_plus(bound, $urandom_range(0, 6000));
			q.req_logical = LOG_W'($urandom_range(0, span - 1));
		end else if (pick < 7) begin
			q.req_physical = PHYS_W'($urandom_range(0, 100000));
			q.req_save = phys_plus(q.req_physical, $urandom_range(0, 6000));
		end else if (pick == 7) begin
			q.req_physical = ts_phys - PHYS_W'(1);
		end
		return q;
	endfunction

	task automatic send_request(input stamp_req_t q, input logic fixed,
		input stamp_rsp_t answer);
		while ($urandom_range(99) < send_gap_pct) begin
			req_bus.valid <= 1'b0;
			@(posedge clk);
		end
		use_fixed = fixed;
		fixed_answer = answer;
		req_bus.valid <= 1'b1;
		req_bus.cmd <= q.cmd;
		req_bus.count <= q.count;
		req_bus.now_ms <= q.now_ms;
		req_bus.req_physical <= q.req_physical;
		req_bus.req_logical <= q.req_logical;
		req_bus.req_save <= q.req_save;
		req_bus.force_req <= q.force_req;
		sent++;
		@(posedge clk);
		while (!req_bus.ready)
			@(posedge clk);
		wait (taken == sent);
	endtask

	// hold off new items until every outstanding response has been checked
	task automatic settle();
		req_bus.valid <= 1'b0;
		wait (stamps_in_flight == 0);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= val;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
	endtask

	task automatic configure(input logic [LIM_W-1:0] lim, input logic [GUARD_W-1:0] grd,
		input logic [SAVE_INT_W-1:0] sint);
		write_reg(REG_LOGICAL_LIMIT, CFG_DATA_W'(lim));
		write_reg(REG_GUARD, CFG_DATA_W'(grd));
		write_reg(REG_SAVE_INT, CFG_DATA_W'(sint));
		cfg_bus.valid <= 1'b0;
		lim_reg = lim;
		guard_reg = grd;
		sint_reg = sint;
	endtask

	always @(posedge clk)
		rsp_bus.ready <= ($urandom_range(99) >= take_stall_pct);

	always @(posedge clk) begin : check_p
		stamp_req_t seen;
		stamp_rsp_t want;
		stamp_rsp_t got;
		logic moved;
		moved = 1'b0;
		if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready)
				moved = 1'b1;
			if (req_bus.valid && req_bus.ready) begin
				seen.cmd = req_bus.cmd;
				seen.count = req_bus.count;
				seen.now_ms = req_bus.now_ms;
				seen.req_physical = req_bus.req_physical;
				seen.req_logical = req_bus.req_logical;
				seen.req_save = req_bus.req_save;
				seen.force_req = req_bus.force_req;
				want = oracle_answer(seen);
				if (use_fixed)
					want = fixed_answer;
				owed_stamps.push_back(want);
				stamps_in_flight++;
				taken++;
				moved = 1'b1;
			end
			if (rsp_bus.valid && rsp_bus.ready) begin
				moved = 1'b1;
				got = rsp_of(rsp_bus.status, rsp_bus.ts_physical, rsp_bus.ts_logical,
					rsp_bus.save_bound, rsp_bus.granted, rsp_bus.leader_flag);
				if (owed_stamps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected response st=%0d phys=%0d log=%0d", got.status,
							got.ts_physical, got.ts_logical);
				end else begin
					want = owed_stamps.pop_front();
					stamps_in_flight--;
					if (got.status !== want.status || got.ts_physical !== want.ts_physical ||
						got.ts_logical !== want.ts_logical ||
						got.save_bound !== want.save_bound ||
						got.granted !== want.granted ||
						got.leader_flag !== want.leader_flag) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch exp: st=%0d phys=%0d log=%0d save=%0d gr=%0d ld=%0b",
								want.status, want.ts_physical, want.ts_logical,
								want.save_bound, want.granted, want.leader_flag);
							$display("         got: st=%0d phys=%0d log=%0d save=%0d gr=%0d ld=%0b",
								got.status, got.ts_physical, got.ts_logical,
								got.save_bound, got.granted, got.leader_flag);
						end
					end
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		script_row_t script[$];
		req_bus.valid = 1'b0;
		req_bus.cmd = CMD_QUERY;
		req_bus.count = '0;
		req_bus.now_ms = '0;
		req_bus.req_physical = '0;
		req_bus.req_logical = '0;
		req_bus.req_save = '0;
		req_bus.force_req = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_LOGICAL_LIMIT;
		cfg_bus.data = '0;
		rsp_bus.ready = 1'b0;

		script.push_back({req_of(CMD_QUERY, 0, 0, 0, 0, 0, 0), 1'b1,
			rsp_of(ST_OK, 0, 0, 0, 0, 0)});
		script.push_back({req_of(CMD_GEN, 5, 0, 0, 0, 0, 0), 1'b1,
			rsp_of(ST_NOT_LEADER, 0, 0, 0, 0, 0)});
		script.push_back({req_of(CMD_TICK, 0, 100, 0, 0, 0, 0), 1'b1,
			rsp_of(ST_NOT_LEADER, 0, 0, 0, 0, 0)});
		script.push_back({req_of(CMD_RESET, 0, 0, 9, 1, 9, 1), 1'b1,
			rsp_of(ST_NOT_LEADER, 0, 0, 0, 0, 0)});
		script.push_back({req_of(CMD_UPDATE, 0, 0, 9, 1, 9, 0), 1'b1,
			rsp_of(ST_NOT_LEADER, 0, 0, 0, 0, 0)});
		script.push_back({req_of(CMD_SPARE, 0, 0, 0, 0, 0, 0), 1'b1,
			rsp_of(ST_OK, 0, 0, 0, 0, 0)});
		script.push_back({req_of(CMD_LEAD_STOP, 0, 0, 0, 0, 0, 0), 1'b1,
			rsp_of(ST_OK, 0, 0, 0, 0, 0)});
		script.push_back({req_of(CMD_LEAD_START, 0, 0, 0, 0, 0, 0), 1'b1,
			rsp_of(ST_OK, 3, 0, 3003, 0, 1)});
		script.push_back({req_of(CMD_GEN, 0, 0, 0, 0, 0, 0), 1'b1,
			rsp_of(ST_BAD_COUNT, 3, 0, 3003, 0, 1)});
		script.push_back({req_of(CMD_GEN, 1000, 0, 0, 0, 0, 0), 1'b1,
			rsp_of(ST_OK, 3, 0, 3003, 1000, 1)});
		script.push_back({req_of(CMD_GEN, CNT_TOP, 0, 0, 0, 0, 0), 1'b1,
			rsp_of(ST_EXHAUSTED, 3, 1000, 3003, 0, 1)});
		script.push_back({req_of(CMD_GEN, 261143, 0, 0, 0, 0, 0), 1'b0, stamp_rsp_t'(0)});
		script.push_back({req_of(CMD_GEN, 1, 0, 0, 0, 0, 0), 1'b0, stamp_rsp_t'(0)});
		script.push_back({req_of(CMD_TICK, 0, 4, 0, 0, 0, 0), 1'b0, stamp_rsp_t'(0)});
		script.push_back({req_of(CMD_TICK, 0, 2, 0, 0, 0, 0), 1'b0, stamp_rsp_t'(0)});
		script.push_back({req_of(CMD_TICK, 0, PHYS_MAX, 0, 0, 0, 0), 1'b0, stamp_rsp_t'(0)});
		script.push_back({req_of(CMD_UPDATE, 0, 0, 5, 0, PHYS_MAX, 0), 1'b1,
			rsp_of(ST_FALLBACK, PHYS_MAX, 0, PHYS_MAX, 0, 1)});
		script.push_back({req_of(CMD_RESET, 0, 0, 0, 0, 0, 0), 1'b0, stamp_rsp_t'(0)});
		script.push_back({req_of(CMD_RESET, 0, 0, 1000, LOG_TOP, 0, 1), 1'b0,
			stamp_rsp_t'(0)});
		script.push_back({req_of(CMD_GEN, 1, 0, 0, 0, 0, 0), 1'b0, stamp_rsp_t'(0)});
		script.push_back({req_of(CMD_LEAD_START, 0, 0, 0, 0, 0, 0), 1'b0, stamp_rsp_t'(0)});
		script.push_back({req_of(CMD_GEN, 1, 0, 0, 0, 0, 0), 1'b0, stamp_rsp_t'(0)});
		script.push_back({req_of(CMD_UPDATE, 0, 0, PHYS_MAX, 7, PHYS_MAX, 0), 1'b0,
			stamp_rsp_t'(0)});
		script.push_back({req_of(CMD_RESET, 0, 0, PHYS_MAX, 0, PHYS_MAX, 0), 1'b0,
			stamp_rsp_t'(0)});
		script.push_back({req_of(CMD_RESET, 0, 0, 0, 0, 0, 1), 1'b0, stamp_rsp_t'(0)});
		script.push_back({req_of(CMD_GEN, 1, 0, 0, 0, 0, 0), 1'b0, stamp_rsp_t'(0)});

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			send_request(script[i].q, script[i].fixed, script[i].answer);

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				settle();
				case (phase)
					1: configure(31'd2, 16'd0, 24'd1);
					2: configure(LOG_SPAN, 16'hFFFF, 24'hFF_FFFF);
					4: configure(31'd1000, 16'd7, 24'd50);
					default: configure(LIM_W'($urandom_range(2, 32'd1073741824)),
						GUARD_W'($urandom_range(0, 200)),
						SAVE_INT_W'($urandom_range(1, 100000)));
				endcase
			end
			if (phase < 2) begin
				send_gap_pct = 12;
				take_stall_pct = 57;
			end else if (phase < 4) begin
				send_gap_pct = 57;
				take_stall_pct = 12;
			end else begin
				send_gap_pct = 0;
				take_stall_pct = 0;
			end
			repeat (ITEMS_PER_PHASE) begin
				if ($urandom_range(63) == 0)
					settle();
				send_request(next_request(), 1'b0, stamp_rsp_t'(0));
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/tso_pkg.sv
rtl/core/tso_req_if.sv
rtl/core/tso_rsp_if.sv
rtl/core/tso_cfg_if.sv
rtl/core/tso_cfg_regs.sv
rtl/core/tso_front.sv
rtl/core/tso_queue.sv
rtl/core/tso_back.sv
rtl/core/timestamp_oracle.sv
sim/testbench.sv
